### sv/lfsa_pkg.sv
package lfsa_pkg;

	// Default table size and the fixed widths of the channel fields.
	localparam int CAPACITY_DEF = 256;
	localparam int SLOT_FIELD_W = 8;
	localparam int STATUS_W     = 2;

	// The free map is held as words of this many slots each.
	localparam int WORD_W = 32;

	// Request codes.
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_REUSED   = 2'd0,
		STATUS_APPENDED = 2'd1,
		STATUS_FULL     = 2'd2,
		STATUS_RELEASE  = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic lookup;  // request beat taken, start the free-map word read
		logic commit;  // word is back and the result slot is free: update and emit
	} ctrl_cmd_t;

endpackage

### sv/lfsa_req_if.sv
interface lfsa_req_if import lfsa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic [SLOT_FIELD_W-1:0] release_slot;

	modport source (output valid, command, release_slot, input ready);
	modport sink (input valid, command, release_slot, output ready);
endinterface

### sv/lfsa_rsp_if.sv
interface lfsa_rsp_if import lfsa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SLOT_FIELD_W-1:0] slot;
	logic [STATUS_W-1:0]     status;
	logic                    release_ok;

	modport source (output valid, slot, status, release_ok, input ready);
	modport sink (input valid, slot, status, release_ok, output ready);
endinterface

### sv/lfsa_ram.sv
module lfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/lfsa_ctrl.sv
module lfsa_ctrl import lfsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd.lookup = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.lookup = req_valid;
			end
			ST_EXEC: begin
				cmd.commit = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_EXEC))
		else $error("accepted request did not move to execute");

	a_valid_rises_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result valid rose without a commit");

	a_valid_falls_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(rsp_ready))
		else $error("result dropped before it was taken");
`endif

endmodule

### sv/lfsa_datapath.sv
module lfsa_datapath import lfsa_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	input  logic                    command,
	input  logic [SLOT_FIELD_W-1:0] release_slot,
	output logic [SLOT_FIELD_W-1:0] slot,
	output status_t                 status,
	output logic                    release_ok
);

	localparam int HW_W   = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (HW_W > SLOT_FIELD_W) ? HW_W : SLOT_FIELD_W;
	localparam int NWORDS = (CAPACITY + WORD_W - 1) / WORD_W;
	localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int FULL_W = WIDX_W + BIT_W;

	// State: high-water mark and one summary bit per free-map word. A word
	// whose summary bit is clear is all zero, whatever the RAM holds.
	logic [HW_W-1:0]   hw_q;
	logic [NWORDS-1:0] summary_q;

	// Request captured at lookup.
	logic                    cmd_q;
	logic [SLOT_FIELD_W-1:0] tgt_q;
	logic [WIDX_W-1:0]       widx_q;
	logic                    wvalid_q;
	logic                    in_range_q;
	logic                    any_q;

	// Result register.
	logic [SLOT_FIELD_W-1:0] slot_q;
	status_t                 status_q;
	logic                    release_ok_q;

	logic                     sum_any;
	logic [WIDX_W-1:0]        sum_pick;
	logic                     in_range;
	logic [WIDX_W+SLOT_FIELD_W-1:0] tgt_wide;
	logic [WIDX_W-1:0]        tgt_widx;
	logic [WIDX_W-1:0]        lookup_widx;
	logic                     lookup_wvalid;

	logic [WORD_W-1:0]  rd_data;
	logic [WORD_W-1:0]  word;
	logic [BIT_W-1:0]   wbit;
	logic [BIT_W-1:0]   tbit;
	logic [FULL_W-1:0]  full_idx;
	logic [FULL_W+SLOT_FIELD_W-1:0] full_ext;
	logic [HW_W+SLOT_FIELD_W-1:0]   hw_ext;
	logic               alloc_hit;
	logic               append_ok;
	logic               rel_ok;
	logic [WORD_W-1:0]  new_word;
	logic               ram_we;

	logic [SLOT_FIELD_W-1:0] res_slot;
	status_t                 res_status;
	logic                    res_ok;

	// Lookup side: lowest word holding a free slot, or the word of the target.
	always_comb begin
		sum_any  = |summary_q;
		sum_pick = '0;
		for (int i = NWORDS - 1; i >= 0; i--) begin
			if (summary_q[i]) begin
				sum_pick = WIDX_W'(i);
			end
		end
	end

	assign in_range = CMP_W'(release_slot) < CMP_W'(hw_q);
	assign tgt_wide = {{WIDX_W{1'b0}}, release_slot};
	assign tgt_widx = in_range ? tgt_wide[BIT_W +: WIDX_W] : '0;

	always_comb begin
		if (command == CMD_RELEASE) begin
			lookup_widx   = tgt_widx;
			lookup_wvalid = in_range && summary_q[tgt_widx];
		end else begin
			lookup_widx   = sum_pick;
			lookup_wvalid = sum_any;
		end
	end

	lfsa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NWORDS)
	) u_free_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_q),
		.wdata (new_word),
		.re    (cmd.lookup),
		.raddr (lookup_widx),
		.rdata (rd_data)
	);

	// Execute side.
	assign word = wvalid_q ? rd_data : '0;

	always_comb begin
		wbit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (word[i]) begin
				wbit = BIT_W'(i);
			end
		end
	end

	assign tbit      = tgt_q[BIT_W-1:0];
	assign full_idx  = {widx_q, wbit};
	assign full_ext  = {{SLOT_FIELD_W{1'b0}}, full_idx};
	assign hw_ext    = {{SLOT_FIELD_W{1'b0}}, hw_q};
	assign alloc_hit = (cmd_q == CMD_ALLOC) && any_q;
	assign append_ok = hw_q != HW_W'(CAPACITY);
	assign rel_ok    = (cmd_q == CMD_RELEASE) && in_range_q && !word[tbit];
	assign new_word  = alloc_hit ? (word & ~(WORD_W'(1) << wbit))
	                             : (word | (WORD_W'(1) << tbit));
	assign ram_we    = cmd.commit && (alloc_hit || rel_ok);

	always_comb begin
		res_slot   = '0;
		res_status = STATUS_RELEASE;
		res_ok     = 1'b0;
		if (cmd_q == CMD_ALLOC) begin
			if (any_q) begin
				res_slot   = full_ext[SLOT_FIELD_W-1:0];
				res_status = STATUS_REUSED;
			end else if (append_ok) begin
				res_slot   = hw_ext[SLOT_FIELD_W-1:0];
				res_status = STATUS_APPENDED;
			end else begin
				res_status = STATUS_FULL;
			end
		end else if (rel_ok) begin
			res_slot = tgt_q;
			res_ok   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q      <= '0;
			summary_q <= '0;
		end else if (cmd.commit) begin
			if (ram_we) begin
				summary_q[widx_q] <= |new_word;
			end
			if ((cmd_q == CMD_ALLOC) && !any_q && append_ok) begin
				hw_q <= hw_q + HW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			cmd_q      <= command;
			tgt_q      <= release_slot;
			widx_q     <= lookup_widx;
			wvalid_q   <= lookup_wvalid;
			in_range_q <= in_range;
			any_q      <= sum_any;
		end
		if (cmd.commit) begin
			slot_q       <= res_slot;
			status_q     <= res_status;
			release_ok_q <= res_ok;
		end
	end

	assign slot       = slot_q;
	assign status     = status_q;
	assign release_ok = release_ok_q;

`ifndef SYNTHESIS
	a_hw_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= HW_W'(CAPACITY))
		else $error("high-water mark beyond capacity");

	a_hw_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hw_q >= $past(hw_q)))
		else $error("high-water mark shrank");

	a_reuse_below_hw: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && alloc_hit) |-> (CMP_W'(full_idx) < CMP_W'(hw_q)))
		else $error("reused slot at or above the high-water mark");
`endif

endmodule

### sv/lowest_free_slot_allocator_core.sv
// Lowest-first slot allocator. Each request beat on req is either an
// allocate (command 0) or a release of release_slot (command 1), and it
// produces exactly one result beat on rsp. An allocate hands back the lowest
// numbered slot that was released earlier (status 0); when none is free it
// hands out the next never-used slot at the high-water mark (status 1), or
// reports full with slot 0 (status 2) once CAPACITY slots are in use. A
// release (status 3) marks a handed-out slot free and echoes it with
// release_ok set; a release of a slot that is already free or was never
// handed out is rejected with slot 0 and release_ok clear, and nothing
// changes. The high-water mark never moves down. When CAPACITY exceeds 256,
// slot carries only the low 8 bits of the slot number, and release_slot can
// name only the first 256 slots. Each request first reads the word of the
// free map that holds the chosen slot from a one-read, one-write RAM, then
// in the execute state updates that word and loads the result register.
// The next request is accepted as soon as the block is back in idle, even
// while the previous result still waits on rsp; it stalls in the execute
// state only if that result has not been taken. No clearing pass is needed
// after reset: a per-word summary bit, cleared by reset, marks which free-map
// words hold any free slot, and a word whose bit is clear reads as empty.
module lowest_free_slot_allocator_core import lfsa_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lfsa_req_if.sink   req,
	lfsa_rsp_if.source rsp
);

	ctrl_cmd_t cmd;
	status_t   status;

	// The controller sequences lookup and commit and owns the result valid.
	lfsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds the free map, the high-water mark and the result
	// register, which keeps its value until the next commit.
	lfsa_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.command      (req.command),
		.release_slot (req.release_slot),
		.slot         (rsp.slot),
		.status       (status),
		.release_ok   (rsp.release_ok)
	);

	assign rsp.status = status;

endmodule

### bench/lowest_free_slot_allocator_core_tb.sv
module lowest_free_slot_allocator_core_tb import lfsa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// The block runs at its default size, so every slot number fits the 8-bit field.
	localparam int TABLE_SLOTS  = CAPACITY_DEF;
	localparam int RANDOM_BEATS = 1330;
	localparam int FILL_BEATS   = 300;
	localparam int N_DIRECTED   = 17;

	// One result beat, in the field order of the rsp channel.
	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] slot;
		status_t                 status;
		logic                    release_ok;
	} alloc_result_t;

	// One request on its way in. A pinned request carries a result typed in by
	// hand, and that result is checked instead of the predicted one.
	typedef struct {
		logic                    command;
		logic [SLOT_FIELD_W-1:0] target;
		bit                      pinned;
		alloc_result_t           result;
	} request_row_t;

	// Traffic mixes for the random segments.
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} traffic_mix_t;

	logic clk;
	logic arst_n;

	lfsa_req_if req();
	lfsa_rsp_if rsp();

	lowest_free_slot_allocator_core #(
		.CAPACITY(TABLE_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Shadow of the allocator: which slots were released and not yet reused,
	// and how many slots have ever been handed out.
	bit slot_free [TABLE_SLOTS];
	int high_water;

	// Results that the accepted requests must produce, oldest first.
	alloc_result_t expected_results [$];
	// Requests that have been put on the channel but not yet accepted.
	request_row_t  request_notes [$];
	int            mismatch_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous limit: every beat may see a long sender gap and a long
	// receiver stall, and the whole run still ends far below this.
	initial begin
		#20_000_000;
		$display("lowest_free_slot_allocator_core: mismatch");
		$finish;
	end

	// Works out the result of one request and moves the shadow state along.
	// An allocate takes the lowest released slot first, then the slot at the
	// high-water mark, and reports full only when neither exists. A release
	// is accepted only for a slot below the high-water mark that is not
	// already free; otherwise it is rejected and nothing changes.
	function automatic alloc_result_t predict_allocation(input logic command,
			input logic [SLOT_FIELD_W-1:0] target);
		alloc_result_t res;
		res = '0;
		if (command == CMD_ALLOC) begin
			for (int i = 0; i < high_water; i++) begin
				if (slot_free[i]) begin
					slot_free[i] = 1'b0;
					res.slot   = SLOT_FIELD_W'(i);
					res.status = STATUS_REUSED;
					return res;
				end
			end
			if (high_water < TABLE_SLOTS) begin
				res.slot   = SLOT_FIELD_W'(high_water);
				res.status = STATUS_APPENDED;
				high_water++;
			end else begin
				res.status = STATUS_FULL;
			end
			return res;
		end
		res.status = STATUS_RELEASE;
		if (int'(target) < high_water && !slot_free[target]) begin
			slot_free[target] = 1'b1;
			res.slot       = target;
			res.release_ok = 1'b1;
		end
		return res;
	endfunction

	// Sender gaps: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 2);
		if (pick < 97)
			return $urandom_range(3, 6);
		return $urandom_range(15, 40);
	endfunction

	// Release targets: mostly a slot that is currently handed out, so that
	// releases get accepted, with some double releases and some noise over the
	// whole field (which also hits slots never handed out early in the run).
	function automatic logic [SLOT_FIELD_W-1:0] pick_release_target();
		int pick;
		int start;
		int idx;
		pick = $urandom_range(0, 99);
		if (high_water == 0 || pick < 15)
			return SLOT_FIELD_W'($urandom_range(0, 255));
		if (pick < 22) begin
			for (int i = 0; i < high_water; i++)
				if (slot_free[i])
					return SLOT_FIELD_W'(i);
		end
		start = $urandom_range(0, high_water - 1);
		for (int i = 0; i < high_water; i++) begin
			idx = (start + i) % high_water;
			if (!slot_free[idx])
				return SLOT_FIELD_W'(idx);
		end
		return SLOT_FIELD_W'(start);
	endfunction

	// Puts one request beat on req and returns at the edge where it is taken.
	// The valid line stays high between back-to-back beats; it drops only for
	// a gap, so it never gets two assignments in one step.
	task automatic send_request(input request_row_t row, input bit gapless);
		int gap;
		gap = gapless ? 0 : pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_notes.push_back(row);
		req.valid        <= 1'b1;
		req.command      <= row.command;
		req.release_slot <= row.target;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: long stretches of ready, short stalls, and a few long ones.
	initial begin : result_sink
		int hold;
		int pick;
		rsp.ready = 1'b0;
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				rsp.ready <= 1'b1;
				hold = $urandom_range(40, 150);
			end else if (pick < 60) begin
				rsp.ready <= 1'b1;
				hold = $urandom_range(1, 12);
			end else if (pick < 95) begin
				rsp.ready <= 1'b0;
				hold = $urandom_range(1, 3);
			end else begin
				rsp.ready <= 1'b0;
				hold = $urandom_range(10, 40);
			end
			repeat (hold) @(posedge clk);
		end
	end

	// Scoreboard. Results are taken first and requests second, all in this
	// one process, so the order of the two within an edge is fixed. Every
	// accepted request runs through the predictor, pinned or not, so that the
	// shadow state stays in step with the block.
	always @(posedge clk) begin : scoreboard
		alloc_result_t want;
		alloc_result_t predicted;
		request_row_t  note;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no request waiting: %s %0d %0d %0d",
						"slot, status, release_ok", rsp.slot, rsp.status,
						rsp.release_ok);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, rsp.slot);
						mismatch_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.release_ok !== want.release_ok) begin
						$error("release_ok: expected %0d, got %0d", want.release_ok,
							rsp.release_ok);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				predicted = predict_allocation(req.command, req.release_slot);
				if (request_notes.size() != 0) begin
					note = request_notes.pop_front();
					expected_results.push_back(note.pinned ? note.result : predicted);
				end else begin
					expected_results.push_back(predicted);
				end
			end
		end
	end

	initial begin : stimulus
		request_row_t directed_rows [N_DIRECTED];
		request_row_t row;
		traffic_mix_t mix;
		int           issued;
		int           seg_len;
		int           alloc_pct;
		int           guard;
		bit           gapless;

		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.command      = CMD_ALLOC;
		req.release_slot = '0;
		mismatch_count   = 0;
		high_water       = 0;

		// Directed opening. Right after reset nothing has been handed out, so
		// both ends of the slot field are rejected releases. Allocates then
		// append from slot 0 upward; a release of a handed-out slot echoes it,
		// a second release of the same slot and a release at the high-water
		// mark are rejected, and the next allocates reuse the lowest freed
		// slots before appending again. The last rows are left to the
		// predictor.
		directed_rows = '{
			'{CMD_RELEASE, 8'd0,   1'b1, '{8'd0, STATUS_RELEASE,  1'b0}},
			'{CMD_RELEASE, 8'd255, 1'b1, '{8'd0, STATUS_RELEASE,  1'b0}},
			'{CMD_ALLOC,   8'd255, 1'b1, '{8'd0, STATUS_APPENDED, 1'b0}},
			'{CMD_ALLOC,   8'd0,   1'b1, '{8'd1, STATUS_APPENDED, 1'b0}},
			'{CMD_ALLOC,   8'd170, 1'b1, '{8'd2, STATUS_APPENDED, 1'b0}},
			'{CMD_ALLOC,   8'd85,  1'b1, '{8'd3, STATUS_APPENDED, 1'b0}},
			'{CMD_RELEASE, 8'd2,   1'b1, '{8'd2, STATUS_RELEASE,  1'b1}},
			'{CMD_RELEASE, 8'd2,   1'b1, '{8'd0, STATUS_RELEASE,  1'b0}},
			'{CMD_RELEASE, 8'd0,   1'b1, '{8'd0, STATUS_RELEASE,  1'b1}},
			'{CMD_RELEASE, 8'd4,   1'b1, '{8'd0, STATUS_RELEASE,  1'b0}},
			'{CMD_ALLOC,   8'd0,   1'b1, '{8'd0, STATUS_REUSED,   1'b0}},
			'{CMD_ALLOC,   8'd255, 1'b1, '{8'd2, STATUS_REUSED,   1'b0}},
			'{CMD_ALLOC,   8'd0,   1'b1, '{8'd4, STATUS_APPENDED, 1'b0}},
			'{CMD_RELEASE, 8'd3,   1'b0, '0},
			'{CMD_RELEASE, 8'd1,   1'b0, '0},
			'{CMD_ALLOC,   8'd15,  1'b0, '0},
			'{CMD_ALLOC,   8'd240, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i], 1'b0);

		// The sender waits here for the block to drain completely.
		wait_drained();

		// Fill phase: enough allocates to use up the freed slots, push the
		// high-water mark to the top, and then see the table report full a few
		// dozen times. The first stretch runs with no sender gaps.
		row.command = CMD_ALLOC;
		row.pinned  = 1'b0;
		row.result  = '0;
		for (issued = 0; issued < FILL_BEATS; issued++) begin
			row.target = SLOT_FIELD_W'($urandom_range(0, 255));
			send_request(row, issued < 100);
		end

		// Random segments with a changing balance of allocates and releases,
		// so that the free map fills and empties many times over. Some
		// segments run without sender gaps, and now and then the sender lets
		// the block drain before going on.
		while (issued < FILL_BEATS + RANDOM_BEATS) begin
			mix     = traffic_mix_t'($urandom_range(0, 2));
			seg_len = $urandom_range(10, 120);
			gapless = ($urandom_range(0, 3) == 0);
			case (mix)
				MIX_FILL:  alloc_pct = 85;
				MIX_DRAIN: alloc_pct = 15;
				default:   alloc_pct = 50;
			endcase
			for (int k = 0; k < seg_len && issued < FILL_BEATS + RANDOM_BEATS; k++) begin
				if ($urandom_range(0, 99) < alloc_pct) begin
					row.command = CMD_ALLOC;
					row.target  = SLOT_FIELD_W'($urandom_range(0, 255));
				end else begin
					row.command = CMD_RELEASE;
					row.target  = pick_release_target();
				end
				send_request(row, gapless);
				issued++;
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		// All requests are in. Wait for the last results, then a few more
		// cycles in case the block sends anything it should not.
		req.valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (expected_results.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("lowest_free_slot_allocator_core: match");
		else
			$display("lowest_free_slot_allocator_core: mismatch");
		$finish;
	end

endmodule
